// ===== rtl/column_row_span_fill_assert.svh =====
// assertion macros for the column/row span fill block
`ifndef COLUMN_ROW_SPAN_FILL_ASSERT_SVH
`define COLUMN_ROW_SPAN_FILL_ASSERT_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define CFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define CFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define CFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/cfs_pkg.sv =====
// constants and codes shared by the column/row span fill block
package cfs_pkg;

    localparam int MAX_WIDTH_DEF  = 640;
    localparam int MAX_HEIGHT_DEF = 480;

    localparam int CFG_W_BITS = 10;
    localparam int CFG_H_BITS = 9;
    localparam int ROW_BITS   = 9;
    localparam int COL_BITS   = 10;
    localparam int PIX_BITS   = 8;
    localparam int OP_BITS    = 2;

    localparam logic [CFG_W_BITS-1:0] CFG_W_RST = 10'd640;
    localparam logic [CFG_H_BITS-1:0] CFG_H_RST = 9'd480;

    localparam logic [PIX_BITS-1:0] WHITE = 8'd255;

    localparam logic [OP_BITS-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_BITS-1:0] OP_FILL  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_READ  = 2'd2;

    // register byte addresses
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd4;

endpackage

// ===== rtl/column_row_span_fill.sv =====
// a write's result is registered in the cycle after acceptance; a read goes through the
//   memory read register and S_RDWAIT before its result is registered (one read port)
// fill: one scan of the active area per pass, one memory read per cycle, plus one write
//   per filled pixel; requests are taken only in S_IDLE, so a read or fill blocks the next
// reset: synchronous, active low; clears control state and restores 640 x 480 config
// the frame memory has no reset and no clearing pass: a pixel is undefined until written
`include "column_row_span_fill_assert.svh"

module column_row_span_fill
    import cfs_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // row[8:0], col[18:9], pixel_in[26:19], zero fill
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]

    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // pixel_out[7:0]
    output logic [1:0]  m_axis_tuser,   // ack_kind[1:0]

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // sizes that follow from the frame limits
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = ($clog2(MAX_WIDTH + 1) > COL_BITS) ? $clog2(MAX_WIDTH + 1) : COL_BITS;
    localparam int YW    = ($clog2(MAX_HEIGHT + 1) > ROW_BITS) ? $clog2(MAX_HEIGHT + 1)
                                                               : ROW_BITS;
    localparam int CW    = (XW > YW) ? XW : YW;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_WRITE  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // configuration registers
    logic [CFG_W_BITS-1:0] r_cfg_w;
    logic [CFG_H_BITS-1:0] r_cfg_h;
    logic                  w_cfg_wr;

    // frame memory, simple dual port, registered read
    logic [PIX_BITS-1:0] mem [DEPTH];
    logic [PIX_BITS-1:0] r_rdata;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       w_raddr;
    logic [PIX_BITS-1:0] w_wdata;

    // sequencer state
    logic [2:0]    r_state, n_state;
    logic          r_pass, n_pass;       // 0 column pass, 1 row pass
    logic [CW-1:0] r_outer, n_outer;     // column (pass 0) or row (pass 1)
    logic [CW-1:0] r_inner, n_inner;     // position along the line
    logic          r_found, n_found;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic          r_rd_vld, n_rd_vld;   // memory data of a scan read arrives
    logic [CW-1:0] r_rd_idx, n_rd_idx;   // line position of that read
    logic          r_rd_inside, n_rd_inside;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [PIX_BITS-1:0] r_out_pixel, n_out_pixel;
    logic [OP_BITS-1:0]  r_out_kind, n_out_kind;

    // request fields
    logic [OP_BITS-1:0]  in_op;
    logic [ROW_BITS-1:0] in_row;
    logic [COL_BITS-1:0] in_col;
    logic [PIX_BITS-1:0] in_px;
    logic                in_acc;
    logic                in_inside;
    logic [AW-1:0]       in_addr;

    // derived geometry
    logic [CW-1:0] act_w, act_h;
    logic [CW-1:0] lim_in, lim_out;
    logic [CW-1:0] scan_row, scan_col;
    logic [AW-1:0] scan_addr;
    logic          hit;
    logic          out_take;
    logic          last_outer;

    assign in_op  = s_axis_tuser;
    assign in_row = s_axis_tdata[8:0];
    assign in_col = s_axis_tdata[18:9];
    assign in_px  = s_axis_tdata[26:19];

    // ---------------------------------------------------------------
    // configuration port: registers decoded on paddr[2]
    // ---------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W_RST;
            r_cfg_h <= CFG_H_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_HEIGHT[2]) begin
                r_cfg_h <= pwdata[CFG_H_BITS-1:0];
            end else begin
                r_cfg_w <= pwdata[CFG_W_BITS-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_HEIGHT[2]) begin
            prdata = 32'(r_cfg_h);
        end else begin
            prdata = 32'(r_cfg_w);
        end
    end

    // oversized settings clamp to the frame limits
    assign act_w = (CW'(r_cfg_w) > CW'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : CW'(r_cfg_w);
    assign act_h = (CW'(r_cfg_h) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(r_cfg_h);

    // ---------------------------------------------------------------
    // addressing: row * MAX_WIDTH + col
    // ---------------------------------------------------------------
    assign in_inside = (CW'(in_row) < act_h) && (CW'(in_col) < act_w);
    assign in_addr   = AW'(AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_col));

    // column pass walks down a column, row pass along a row
    assign scan_row  = r_pass ? r_outer : r_inner;
    assign scan_col  = r_pass ? r_inner : r_outer;
    assign scan_addr = AW'(AW'(scan_row) * AW'(MAX_WIDTH) + AW'(scan_col));
    assign lim_in    = r_pass ? act_w : act_h;
    assign lim_out   = r_pass ? act_h : act_w;
    assign last_outer = (r_outer == lim_out - CW'(1));

    assign hit = r_rd_vld && (r_rdata == WHITE);

    // ---------------------------------------------------------------
    // handshake
    // ---------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_out_valid && m_axis_tready;

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_outer     = r_outer;
        n_inner     = r_inner;
        n_found     = r_found;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_inner;
        n_rd_inside = r_rd_inside;
        n_out_valid = r_out_valid && !out_take;
        n_out_pixel = r_out_pixel;
        n_out_kind  = r_out_kind;
        w_we        = 1'b0;
        w_waddr     = scan_addr;
        w_raddr     = scan_addr;
        w_wdata     = WHITE;

        // track the first and last white pixel seen along the line
        if (hit) begin
            if (!r_found) begin
                n_lo = r_rd_idx;
            end
            n_hi    = r_rd_idx;
            n_found = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                w_raddr = in_addr;
                if (in_acc) begin
                    case (in_op)
                        OP_WRITE: begin
                            w_we        = in_inside;
                            w_waddr     = in_addr;
                            w_wdata     = in_px;
                            n_out_valid = 1'b1;
                            n_out_pixel = '0;
                            n_out_kind  = OP_WRITE;
                        end
                        OP_FILL: begin
                            if (act_w == '0 || act_h == '0) begin
                                n_state = S_DONE;
                            end else begin
                                n_pass  = 1'b0;
                                n_outer = '0;
                                n_inner = '0;
                                n_found = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        OP_READ: begin
                            n_rd_inside = in_inside;
                            n_state     = S_RDWAIT;
                        end
                        default: begin
                            // unused opcode: taken, no result
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                n_out_valid = 1'b1;
                n_out_pixel = r_rd_inside ? r_rdata : '0;
                n_out_kind  = OP_READ;
                n_state     = S_IDLE;
            end
            S_SCAN: begin
                // one read per cycle along the line
                n_rd_vld = 1'b1;
                if (r_inner == lim_in - CW'(1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_inner = r_inner + CW'(1);
                end
            end
            S_DRAIN: begin
                // last read's data is in; decide on the span
                if (n_found) begin
                    n_inner = n_lo;
                    n_state = S_WRITE;
                end else begin
                    n_found = 1'b0;
                    n_inner = '0;
                    if (last_outer) begin
                        n_outer = '0;
                        n_pass  = 1'b1;
                        n_state = r_pass ? S_DONE : S_SCAN;
                    end else begin
                        n_outer = r_outer + CW'(1);
                        n_state = S_SCAN;
                    end
                end
            end
            S_WRITE: begin
                // paint the span white, one pixel per cycle
                w_we    = 1'b1;
                w_wdata = WHITE;
                if (r_inner == r_hi) begin
                    n_found = 1'b0;
                    n_inner = '0;
                    if (last_outer) begin
                        n_outer = '0;
                        n_pass  = 1'b1;
                        n_state = r_pass ? S_DONE : S_SCAN;
                    end else begin
                        n_outer = r_outer + CW'(1);
                        n_state = S_SCAN;
                    end
                end else begin
                    n_inner = r_inner + CW'(1);
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_out_pixel = '0;
                n_out_kind  = OP_FILL;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= 1'b0;
            r_found     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pass      <= n_pass;
            r_found     <= n_found;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_outer     <= n_outer;
        r_inner     <= n_inner;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_rd_idx    <= n_rd_idx;
        r_rd_inside <= n_rd_inside;
        r_out_pixel <= n_out_pixel;
        r_out_kind  <= n_out_kind;
    end

    // frame memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pixel;
    assign m_axis_tuser  = r_out_kind;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `CFS_ASSERT_SAME(a_no_write_in_scan, i_clk, i_rst_n,
        (r_state == S_SCAN || r_state == S_DRAIN), !w_we, "memory written during a scan")
    `CFS_ASSERT_SAME(a_drain_has_data, i_clk, i_rst_n,
        (r_state == S_DRAIN), r_rd_vld, "drain without pending read data")
    `CFS_ASSERT_SAME(a_span_bounds, i_clk, i_rst_n,
        (r_state == S_WRITE), (r_found && r_inner <= r_hi), "span write outside bounds")
    `CFS_ASSERT_NEXT(a_fill_ack, i_clk, i_rst_n,
        (r_state == S_DONE), (r_out_valid && r_out_kind == OP_FILL), "fill result not posted")

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the column/row span fill block
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cfs_pkg::*;

    localparam int FRAME_W      = MAX_WIDTH_DEF;
    localparam int FRAME_H      = MAX_HEIGHT_DEF;
    localparam int FRAME_PIXELS = FRAME_W * FRAME_H;

    // opcode the block must swallow without an ack
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    // a correct run stays far below this, keep a wide margin
    localparam int CYCLE_LIMIT   = 3_000_000;
    // idle cycles after the last ack, covers an unused-opcode request still in flight
    localparam int SETTLE_CYCLES = 16;
    // areas up to this size get every pixel written so that fills are legal
    localparam int PREFILL_LIMIT = 256;
    localparam int REPORT_LINES  = 100;
    localparam int PHASES        = 15;
    localparam int PHASE_ITEMS   = 70;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        logic [OP_BITS-1:0]  kind;
    } t_ack;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // row[8:0], col[18:9], pixel_in[26:19], zero fill
    logic [1:0]  s_axis_tuser  = '0;   // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // pixel_out[7:0]
    logic [1:0]  m_axis_tuser;         // ack_kind[1:0]
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // predicted block state: frame contents, size registers, last filled span
    logic [PIX_BITS-1:0]   frame_px [FRAME_PIXELS];
    logic [CFG_W_BITS-1:0] cfg_width  = CFG_W_RST;
    logic [CFG_H_BITS-1:0] cfg_height = CFG_H_RST;
    logic [COL_BITS-1:0]   span_lo    = '0;
    logic [COL_BITS-1:0]   span_hi    = '0;
    t_ack                  pending_acks [$];

    // stimulus bookkeeping: which pixels have been written since reset
    bit px_written [FRAME_PIXELS];
    int written_addrs [$];
    bit area_ready      = 1'b0;
    int send_gap_max    = 8;
    int recv_gap_max    = 8;
    int hold_cycles     = 0;
    int recv_stall_left = 0;
    int mismatches      = 0;
    int cycle_count     = 0;

    column_row_span_fill #(
        .MAX_WIDTH (MAX_WIDTH_DEF),
        .MAX_HEIGHT(MAX_HEIGHT_DEF)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= REPORT_LINES)
            $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // size registers above the frame limits act as the limit
    function automatic int active_w();
        return (cfg_width > FRAME_W) ? FRAME_W : int'(cfg_width);
    endfunction

    function automatic int active_h();
        return (cfg_height > FRAME_H) ? FRAME_H : int'(cfg_height);
    endfunction

    // column pass first, then the row pass on its result
    function automatic void span_fill();
        int  w;
        int  h;
        int  lo;
        int  hi;
        bit  found;
        w = active_w();
        h = active_h();
        for (int c = 0; c < w; c++) begin
            found = 1'b0;
            lo    = 0;
            hi    = 0;
            for (int r = 0; r < h; r++) begin
                if (frame_px[r * FRAME_W + c] == WHITE) begin
                    if (!found)
                        lo = r;
                    hi    = r;
                    found = 1'b1;
                end
            end
            if (found) begin
                for (int r = lo; r <= hi; r++)
                    frame_px[r * FRAME_W + c] = WHITE;
                span_lo = COL_BITS'(lo);
                span_hi = COL_BITS'(hi);
            end
        end
        for (int r = 0; r < h; r++) begin
            found = 1'b0;
            lo    = 0;
            hi    = 0;
            for (int c = 0; c < w; c++) begin
                if (frame_px[r * FRAME_W + c] == WHITE) begin
                    if (!found)
                        lo = c;
                    hi    = c;
                    found = 1'b1;
                end
            end
            if (found) begin
                for (int c = lo; c <= hi; c++)
                    frame_px[r * FRAME_W + c] = WHITE;
                span_lo = COL_BITS'(lo);
                span_hi = COL_BITS'(hi);
            end
        end
    endfunction

    // update the predicted frame for one accepted request and queue its ack
    function automatic void predict_ack(logic [OP_BITS-1:0] op, logic [31:0] data);
        logic [ROW_BITS-1:0] r;
        logic [COL_BITS-1:0] c;
        logic [PIX_BITS-1:0] px;
        bit                  in_area;
        int                  a;
        t_ack                ack;
        r       = data[8:0];
        c       = data[18:9];
        px      = data[26:19];
        in_area = (int'(r) < active_h()) && (int'(c) < active_w());
        a       = int'(r) * FRAME_W + int'(c);
        ack.pixel = '0;
        ack.kind  = op;
        case (op)
            OP_WRITE: begin
                if (in_area)
                    frame_px[a] = px;
            end
            OP_FILL: begin
                span_fill();
            end
            OP_READ: begin
                if (in_area)
                    ack.pixel = frame_px[a];
            end
            default: begin
                // unused opcode: no ack at all
                return;
            end
        endcase
        pending_acks.push_back(ack);
    endfunction

    // requests are predicted before acks are checked in the same edge, so order is kept
    always @(posedge i_clk) begin : ack_check
        t_ack want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                predict_ack(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_acks.size() == 0) begin
                    report_mismatch("ack with no request waiting", m_axis_tuser, -1);
                end else begin
                    want = pending_acks.pop_front();
                    if (m_axis_tdata !== want.pixel)
                        report_mismatch("pixel_out", m_axis_tdata, want.pixel);
                    if (m_axis_tuser !== want.kind)
                        report_mismatch("ack_kind", m_axis_tuser, want.kind);
                end
            end
        end
    end

    // result side pacing: a long hold when asked, else a random stall after each ack
    always @(posedge i_clk) begin : ready_pacing
        logic ready_next;
        if (hold_cycles > 0) begin
            hold_cycles--;
            ready_next = 1'b0;
        end else if (recv_stall_left > 0) begin
            recv_stall_left--;
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
            if (m_axis_tvalid && m_axis_tready) begin
                recv_stall_left = $urandom_range(0, recv_gap_max);
                if (recv_stall_left > 0) begin
                    recv_stall_left--;
                    ready_next = 1'b0;
                end
            end
        end
        m_axis_tready <= ready_next;
    end

    // one request; tvalid stays high on return so a back-to-back request needs no drop
    task automatic send_request(logic [OP_BITS-1:0] op, int row, int col,
                                logic [PIX_BITS-1:0] px);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, px, COL_BITS'(col), ROW_BITS'(row)};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_pixel(int row, int col, logic [PIX_BITS-1:0] value);
        int a;
        a = row * FRAME_W + col;
        if (row < active_h() && col < active_w() && !px_written[a]) begin
            px_written[a] = 1'b1;
            written_addrs.push_back(a);
        end
        send_request(OP_WRITE, row, col, value);
    endtask

    task automatic read_pixel(int row, int col);
        send_request(OP_READ, row, col, PIX_BITS'($urandom_range(0, 255)));
    endtask

    // drop tvalid, let the last acceptance reach the predictor, wait for all acks
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_acks.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == REG_WIDTH)
            cfg_width = value[CFG_W_BITS-1:0];
        else
            cfg_height = value[CFG_H_BITS-1:0];
        @(posedge i_clk);
    endtask

    task automatic read_register(logic [2:0] addr, output logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        value   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [PIX_BITS-1:0] pick_pixel();
        if ($urandom_range(0, 2) == 0)
            return WHITE;
        return PIX_BITS'($urandom_range(0, 255));
    endfunction

    // a coordinate outside the active area, anywhere the field widths allow
    function automatic void pick_outside(output int row, output int col);
        if ($urandom_range(0, 1)) begin
            row = $urandom_range(active_h(), 511);
            col = $urandom_range(0, 1023);
        end else begin
            row = $urandom_range(0, 511);
            col = $urandom_range(active_w(), 1023);
        end
    endfunction

    // new frame size; small areas get every unwritten pixel written so fills stay legal
    task automatic configure_frame(int width, int height);
        logic [31:0] readback;
        int          aw;
        int          ah;
        write_register(REG_WIDTH, 32'(width));
        write_register(REG_HEIGHT, 32'(height));
        read_register(REG_WIDTH, readback);
        if (readback !== 32'(width & ((1 << CFG_W_BITS) - 1)))
            report_mismatch("image_width readback", readback, width);
        read_register(REG_HEIGHT, readback);
        if (readback !== 32'(height & ((1 << CFG_H_BITS) - 1)))
            report_mismatch("image_height readback", readback, height);
        aw = active_w();
        ah = active_h();
        area_ready = (aw * ah <= PREFILL_LIMIT);
        if (area_ready) begin
            for (int r = 0; r < ah; r++)
                for (int c = 0; c < aw; c++)
                    if (!px_written[r * FRAME_W + c])
                        write_pixel(r, c, pick_pixel());
        end
    endtask

    // mostly in-area writes and reads, some fills, out-of-area accesses and unused opcodes
    task automatic send_random_item();
        int sel;
        int row;
        int col;
        int a;
        bit has_area;
        sel      = $urandom_range(0, 99);
        has_area = active_w() > 0 && active_h() > 0;
        if (sel < 3) begin
            send_request(OP_UNUSED, $urandom_range(0, 511), $urandom_range(0, 1023),
                         PIX_BITS'($urandom_range(0, 255)));
        end else if (sel < 11 && area_ready) begin
            send_request(OP_FILL, $urandom_range(0, 511), $urandom_range(0, 1023),
                         PIX_BITS'($urandom_range(0, 255)));
        end else if (sel < 55) begin
            if (has_area && $urandom_range(0, 9) != 0) begin
                row = $urandom_range(0, active_h() - 1);
                col = $urandom_range(0, active_w() - 1);
            end else begin
                pick_outside(row, col);
            end
            write_pixel(row, col, pick_pixel());
        end else begin
            if (!has_area || $urandom_range(0, 9) == 0 || written_addrs.size() == 0) begin
                pick_outside(row, col);
            end else if (area_ready) begin
                row = $urandom_range(0, active_h() - 1);
                col = $urandom_range(0, active_w() - 1);
            end else begin
                // big area: only pixels known to be written
                a   = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
                row = a / FRAME_W;
                col = a % FRAME_W;
            end
            read_pixel(row, col);
        end
    endtask

    task automatic test_register_reset();
        logic [31:0] readback;
        read_register(REG_WIDTH, readback);
        if (readback !== 32'(CFG_W_RST))
            report_mismatch("image_width after reset", readback, CFG_W_RST);
        read_register(REG_HEIGHT, readback);
        if (readback !== 32'(CFG_H_RST))
            report_mismatch("image_height after reset", readback, CFG_H_RST);
    endtask

    // frame corners and high address bits at full size, out-of-area accesses, unused opcode
    task automatic test_corner_pixels();
        write_pixel(0, 0, 8'h00);
        write_pixel(0, 639, WHITE);
        write_pixel(479, 0, 8'hAA);
        write_pixel(479, 639, 8'h55);
        write_pixel(256, 512, 8'h01);
        write_pixel(300, 600, 8'hFE);
        read_pixel(0, 0);
        read_pixel(0, 639);
        read_pixel(479, 0);
        read_pixel(479, 639);
        read_pixel(256, 512);
        read_pixel(300, 600);
        write_pixel(480, 0, WHITE);
        write_pixel(0, 640, 8'h07);
        write_pixel(511, 1023, WHITE);
        read_pixel(480, 0);
        read_pixel(0, 640);
        read_pixel(511, 1023);
        send_request(OP_UNUSED, 511, 1023, WHITE);
        read_pixel(479, 639);
        wait_drain();
    endtask

    // a 4x4 frame with a column span, a row span, columns and a row without white
    task automatic test_span_fill_pattern();
        int pattern [4][4] = '{
            '{255,   0,   7, 255},
            '{  0, 254,   0,   0},
            '{255,   0,   0, 128},
            '{  1,   2,   3,   4}
        };
        configure_frame(4, 4);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                write_pixel(r, c, PIX_BITS'(pattern[r][c]));
        send_request(OP_FILL, 0, 0, 8'h00);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                read_pixel(r, c);
        // a second fill over an already filled frame changes nothing
        send_request(OP_FILL, 0, 0, 8'h00);
        read_pixel(1, 0);
        read_pixel(1, 1);
        wait_drain();
    endtask

    // zero-size areas ignore everything; oversized registers act as the frame limits
    task automatic test_empty_and_oversized();
        configure_frame(0, 480);
        write_pixel(0, 0, 8'h63);
        read_pixel(0, 0);
        send_request(OP_FILL, 0, 0, 8'h00);
        read_pixel(5, 0);
        wait_drain();
        configure_frame(640, 0);
        write_pixel(0, 5, WHITE);
        send_request(OP_FILL, 0, 0, 8'h00);
        read_pixel(0, 5);
        wait_drain();
        configure_frame(1023, 511);
        write_pixel(479, 639, 8'h3C);
        read_pixel(479, 639);
        read_pixel(480, 0);
        read_pixel(0, 640);
        send_request(OP_UNUSED, 0, 0, 8'h00);
        wait_drain();
    endtask

    // frame sizes from the extremes down to a few pixels, idle patterns rotating among four
    task automatic test_random_phases();
        int phase_w [12] = '{3, 640, 1, 16, 0, 7, 1023, 2, 640, 1, 24, 5};
        int phase_h [12] = '{2, 1, 480, 16, 5, 0, 2, 511, 480, 1, 24, 9};
        int w;
        int h;
        for (int i = 0; i < PHASES; i++) begin
            if (i < 12) begin
                w = phase_w[i];
                h = phase_h[i];
            end else begin
                w = $urandom_range(1, 20);
                h = $urandom_range(1, 20);
            end
            case (i % 4)
                0: begin send_gap_max = 0; recv_gap_max = 0; end
                1: begin send_gap_max = 8; recv_gap_max = 8; end
                2: begin send_gap_max = 0; recv_gap_max = 8; end
                default: begin send_gap_max = 8; recv_gap_max = 0; end
            endcase
            configure_frame(w, h);
            repeat (PHASE_ITEMS) send_random_item();
            wait_drain();
        end
    endtask

    // the result side holds off while requests keep coming, so the input must stall
    task automatic test_output_hold();
        send_gap_max = 0;
        recv_gap_max = 0;
        configure_frame(8, 8);
        hold_cycles = 300;
        repeat (80) send_random_item();
        wait_drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_reset();
        test_corner_pixels();
        test_span_fill_pattern();
        test_empty_and_oversized();
        test_random_phases();
        test_output_hold();
        wait_drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cfs_pkg.sv
rtl/column_row_span_fill.sv
tb/sv/tb.sv
